>>> rtl/ccp_pkg.sv
// Shared types, codes and helper functions for the color command parser.
package ccp_pkg;

  localparam int NUM_WIDTH_DEF = 10;
  localparam int VAL_W         = 9;
  localparam int KW_COUNT      = 4;

  localparam logic [8:0] LEVEL_LIMIT_RST = 9'd100;
  localparam logic [8:0] HUE_LIMIT_RST   = 9'd360;

  // keyword_match bit positions
  localparam int KW_RGB  = 0;
  localparam int KW_HSV  = 1;
  localparam int KW_SAVE = 2;
  localparam int KW_HELP = 3;

  typedef enum logic [2:0] {
    KIND_EMPTY   = 3'd0,
    KIND_UNKNOWN = 3'd1,
    KIND_RGB     = 3'd2,
    KIND_HSV     = 3'd3,
    KIND_SAVE    = 3'd4,
    KIND_HELP    = 3'd5
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } num_phase_t;

  typedef enum logic [1:0] {
    REG_LEVEL_LIMIT = 2'd0,
    REG_HUE_LIMIT   = 2'd1
  } cfg_reg_t;

  // classified character item
  typedef struct packed {
    logic       is_end;
    logic       is_space;
    logic       is_letter;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
    logic [3:0] digit;
    logic [7:0] ch;
  } char_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [8:0] v0;
    logic [8:0] v1;
    logic [8:0] v2;
  } result_t;

  function automatic logic [4:0] kw_len(input logic [1:0] k);
    logic [4:0] len;
    case (k)
      2'd0:    len = 5'd3;
      2'd1:    len = 5'd3;
      default: len = 5'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [1:0] pos);
    logic [7:0] c;
    case ({k, pos})
      4'b00_00: c = "r";
      4'b00_01: c = "g";
      4'b00_10: c = "b";
      4'b01_00: c = "h";
      4'b01_01: c = "s";
      4'b01_10: c = "v";
      4'b10_00: c = "s";
      4'b10_01: c = "a";
      4'b10_10: c = "v";
      4'b10_11: c = "e";
      4'b11_00: c = "h";
      4'b11_01: c = "e";
      4'b11_10: c = "l";
      4'b11_11: c = "p";
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] clamp_to(input logic [8:0] v, input logic [8:0] limit);
    return (v > limit) ? limit : v;
  endfunction

endpackage

>>> rtl/ccp_front.sv
// Front end: takes characters, classifies them and queues them for the back end.
module ccp_front import ccp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] ch,
  input  logic       end_of_command,
  output logic       full,
  output logic       item_valid,
  output char_item_t item,
  input  logic       item_pop
);

  char_item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  char_item_t cls;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    cls           = '0;
    cls.ch        = ch;
    cls.is_end    = end_of_command;
    cls.is_space  = (ch == 8'h20);
    cls.is_letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    cls.is_digit  = (ch >= "0" && ch <= "9");
    cls.is_sign   = (ch == "+") || (ch == "-");
    cls.is_minus  = (ch == "-");
    cls.digit     = ch[3:0];
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/ccp_back.sv
// Back end: token and number state, builds one result per end marker.
module ccp_back import ccp_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  char_item_t item,
  output logic       item_pop,
  input  logic [8:0] level_limit,
  input  logic [8:0] hue_limit,
  input  logic       res_full,
  output logic       res_push,
  output result_t    res
);

  localparam logic [2:0] TOKEN_CAP = 3'd7;
  localparam logic [4:0] POS_CAP   = 5'd31;

  logic [2:0]           token_count, token_count_next;
  logic                 inside_token, inside_token_next;
  logic [4:0]           char_position, char_position_next;
  logic                 first_all_letters, first_all_letters_next;
  logic [3:0]           keyword_match, keyword_match_next;
  logic                 args_all_numeric, args_all_numeric_next;
  num_phase_t           number_phase, number_phase_next;
  logic                 number_negative, number_negative_next;
  logic [NUM_WIDTH-1:0] number_accum, number_accum_next;
  logic [8:0]           arg_values [3];
  logic [8:0]           arg_values_next [3];

  logic [2:0]           idx;
  logic [1:0]           arg_idx;
  logic [NUM_WIDTH+3:0] prod;
  logic [8:0]           sat_val;
  logic                 args_ok;

  always_comb begin
    token_count_next       = token_count;
    inside_token_next      = inside_token;
    char_position_next     = char_position;
    first_all_letters_next = first_all_letters;
    keyword_match_next     = keyword_match;
    args_all_numeric_next  = args_all_numeric;
    number_phase_next      = number_phase;
    number_negative_next   = number_negative;
    number_accum_next      = number_accum;
    arg_values_next        = arg_values;
    res                    = '0;
    res.kind               = KIND_EMPTY;
    res_push               = 1'b0;
    idx                    = 3'd0;
    arg_idx                = 2'd0;
    prod                   = '0;
    args_ok                = 1'b0;
    sat_val                = (|number_accum[NUM_WIDTH-1:9]) ? 9'd511 : number_accum[8:0];
    item_pop               = item_valid && (!item.is_end || !res_full);

    if (item_pop) begin
      if (item.is_end || item.is_space) begin
        // close the open token
        if (inside_token) begin
          idx     = token_count - 3'd1;
          arg_idx = idx[1:0] - 2'd1;
          if (idx == 3'd0) begin
            for (int k = 0; k < KW_COUNT; k++) begin
              if (char_position != kw_len(2'(k))) keyword_match_next[k] = 1'b0;
            end
          end else if (idx <= 3'd3) begin
            arg_values_next[arg_idx] = number_negative ? 9'd0 : sat_val;
          end
          inside_token_next = 1'b0;
        end
        if (item.is_end) begin
          res_push = 1'b1;
          args_ok  = (token_count == 3'd4) && args_all_numeric;
          if (token_count == 3'd0) begin
            res.kind = KIND_EMPTY;
          end else if (!first_all_letters) begin
            res.kind = KIND_UNKNOWN;
          end else if (keyword_match_next[KW_RGB] && args_ok) begin
            res.kind = KIND_RGB;
            res.v0   = clamp_to(arg_values_next[0], level_limit);
            res.v1   = clamp_to(arg_values_next[1], level_limit);
            res.v2   = clamp_to(arg_values_next[2], level_limit);
          end else if (keyword_match_next[KW_HSV] && args_ok) begin
            res.kind = KIND_HSV;
            res.v0   = clamp_to(arg_values_next[0], hue_limit);
            res.v1   = clamp_to(arg_values_next[1], level_limit);
            res.v2   = clamp_to(arg_values_next[2], level_limit);
          end else if (keyword_match_next[KW_SAVE] && token_count == 3'd1) begin
            res.kind = KIND_SAVE;
          end else if (keyword_match_next[KW_HELP] && token_count == 3'd1) begin
            res.kind = KIND_HELP;
          end else begin
            res.kind = KIND_UNKNOWN;
          end
          token_count_next       = 3'd0;
          inside_token_next      = 1'b0;
          char_position_next     = 5'd0;
          first_all_letters_next = 1'b1;
          keyword_match_next     = 4'hF;
          args_all_numeric_next  = 1'b1;
          number_phase_next      = PH_START;
          number_negative_next   = 1'b0;
          number_accum_next      = '0;
          for (int i = 0; i < 3; i++) arg_values_next[i] = 9'd0;
        end
      end else begin
        if (!inside_token) begin
          inside_token_next    = 1'b1;
          if (token_count != TOKEN_CAP) token_count_next = token_count + 3'd1;
          char_position_next   = 5'd0;
          number_phase_next    = PH_START;
          number_negative_next = 1'b0;
          number_accum_next    = '0;
        end
        idx = token_count_next - 3'd1;
        if (idx == 3'd0) begin
          if (!item.is_letter) first_all_letters_next = 1'b0;
          for (int k = 0; k < KW_COUNT; k++) begin
            if (char_position_next >= kw_len(2'(k)) ||
                kw_char(2'(k), char_position_next[1:0]) != item.ch)
              keyword_match_next[k] = 1'b0;
          end
        end else if (idx <= 3'd3) begin
          if (item.is_sign) begin
            if (number_phase_next == PH_START) begin
              number_phase_next    = PH_SIGN;
              number_negative_next = item.is_minus;
            end else begin
              number_phase_next = PH_STOP;
            end
          end else if (item.is_digit) begin
            if (number_phase_next != PH_STOP) begin
              // acc*10 + digit, saturating
              prod = {1'b0, number_accum_next, 3'b000} + {3'b000, number_accum_next, 1'b0}
                   + {{NUM_WIDTH{1'b0}}, item.digit};
              number_accum_next = (|prod[NUM_WIDTH+3:NUM_WIDTH]) ? {NUM_WIDTH{1'b1}}
                                                                 : prod[NUM_WIDTH-1:0];
              number_phase_next = PH_DIGITS;
            end
          end else begin
            args_all_numeric_next = 1'b0;
          end
        end
        if (char_position_next != POS_CAP) char_position_next = char_position_next + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_count       <= 3'd0;
      inside_token      <= 1'b0;
      char_position     <= 5'd0;
      first_all_letters <= 1'b1;
      keyword_match     <= 4'hF;
      args_all_numeric  <= 1'b1;
      number_phase      <= PH_START;
      number_negative   <= 1'b0;
      number_accum      <= '0;
      for (int i = 0; i < 3; i++) arg_values[i] <= 9'd0;
    end else begin
      token_count       <= token_count_next;
      inside_token      <= inside_token_next;
      char_position     <= char_position_next;
      first_all_letters <= first_all_letters_next;
      keyword_match     <= keyword_match_next;
      args_all_numeric  <= args_all_numeric_next;
      number_phase      <= number_phase_next;
      number_negative   <= number_negative_next;
      number_accum      <= number_accum_next;
      arg_values        <= arg_values_next;
    end
  end

endmodule

>>> rtl/ccp_result_queue.sv
// Two-entry queue holding finished results until they are popped.
module ccp_result_queue import ccp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  output result_t head,
  input  logic    pop
);

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = q[rd_ptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) q[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= ~wr_ptr;
      if (do_pop)   rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, res_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/color_command_parser_unit.sv
// A character is classified on entry, queued, and parsed at the queue head; the result
// of an end marker enters the result queue when the marker is accepted. Throughput: one
// character or end marker per cycle, set by the parse state update in the back end; an end
// marker waits on a full result queue, and two-entry queues decouple both sides.
// Reset (synchronous, rst high) empties both queues, clears the parse state and sets the
// limits to level 100 and hue 360.
module color_command_parser_unit import ccp_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       end_of_command,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] cmd_kind,
  output logic [8:0] first_value,
  output logic [8:0] second_value,
  output logic [8:0] third_value,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic       level_limit;
  logic [8:0] level_lim;
  logic [8:0] hue_lim;
  logic       item_valid;
  char_item_t item;
  logic       item_pop;
  logic       res_full;
  logic       res_push;
  result_t    res;
  result_t    head;

  assign cfg_ready   = 1'b1;
  assign level_limit = cfg_valid && (cfg_index == REG_LEVEL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      level_lim <= LEVEL_LIMIT_RST;
      hue_lim   <= HUE_LIMIT_RST;
    end else begin
      if (level_limit) level_lim <= cfg_data;
      if (cfg_valid && cfg_index == REG_HUE_LIMIT) hue_lim <= cfg_data;
    end
  end

  ccp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .ch             (ch),
    .end_of_command (end_of_command),
    .full           (full),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop)
  );

  ccp_back #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .level_limit (level_lim),
    .hue_limit   (hue_lim),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  ccp_result_queue u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .head     (head),
    .pop      (pop)
  );

  assign cmd_kind     = head.kind;
  assign first_value  = head.v0;
  assign second_value = head.v1;
  assign third_value  = head.v2;

endmodule

>>> rtl/ccp_checker.sv
// Port-level checks for the color command parser, bound to the top level.
module ccp_checker import ccp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] cmd_kind,
  input logic [8:0] first_value,
  input logic [8:0] second_value,
  input logic [8:0] third_value
);

  // both sides come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cmd_kind <= KIND_HELP))
    else $error("result kind out of range");

  // only color commands carry values
  a_zero_values: assert property (@(posedge clk) disable iff (rst)
    (!empty && cmd_kind != KIND_RGB && cmd_kind != KIND_HSV) |->
      (first_value == 9'd0 && second_value == 9'd0 && third_value == 9'd0))
    else $error("nonzero values on a non-color result");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(cmd_kind) && $stable(first_value) &&
                          $stable(second_value) && $stable(third_value)))
    else $error("waiting result changed");

endmodule

bind color_command_parser_unit ccp_checker u_ccp_checker (.*);
